[src/iqa_pkg.sv]
// Shared types and constants for the integer quaternion ALU.
// Holds the operation codes, field widths and the Hamilton product term table.
// No dependencies.
package iqa_pkg;

  // Field widths.
  localparam int unsigned CmdW  = 3;
  localparam int unsigned CompW = 16;
  localparam int unsigned ProdW = 2 * CompW;
  localparam int unsigned ResW  = 34;
  localparam int unsigned NComp = 4;

  // Operation codes carried on the input tuser.
  typedef enum logic [CmdW-1:0] {
    CMD_ADD      = 3'd0,
    CMD_SUB      = 3'd1,
    CMD_MUL      = 3'd2,
    CMD_MUL_CONJ = 3'd3,
    CMD_CONJ     = 3'd4,
    CMD_SQUARE   = 3'd5
  } cmd_e;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [ResW-1:0]  res_t;

  // Hamilton product p*q: result component c is the signed sum over t of
  // p[TermPIdx[c][t]] * q[TermQIdx[c][t]], negated where TermNeg is set.
  // Component order is real, i, j, k.
  localparam logic [1:0] TermPIdx [NComp][NComp] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3}
  };
  localparam logic [1:0] TermQIdx [NComp][NComp] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };
  localparam logic TermNeg [NComp][NComp] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

endpackage

[src/integer_quaternion_alu_unit.sv]
// Integer quaternion ALU: add, subtract, Hamilton product, product with the
// conjugate, conjugate and component-wise square. Uses iqa_pkg.
// Each input beat is registered in stage 1, then in the output register.
// Throughput is one beat per cycle unless stalled; the 16 parallel 16x16 multipliers
// in the first stage and the four-term adders in the second set the cycle time.
// The pipeline stalls as a whole only while the output beat is not taken.
// Reset clears the stage valid flags; data registers are not reset.
module integer_quaternion_alu_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // p_real, p_i, p_j, p_k, q_real, q_i, q_j, q_k (16 bits signed each), lowest first.
  input  logic [127:0] s_axis_tdata_i,
  // cmd (3 bits).
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // r_real, r_i, r_j, r_k (34 bits signed each), lowest first.
  output logic [135:0] m_axis_tdata_o
);

  localparam int unsigned NComp = iqa_pkg::NComp;
  localparam int unsigned CompW = iqa_pkg::CompW;

  logic                advance;
  iqa_pkg::cmd_e       cmd_in;
  iqa_pkg::comp_t      p_op [NComp];
  iqa_pkg::comp_t      q_op [NComp];
  iqa_pkg::comp_t      a_op [NComp];

  logic                valid1_q;
  iqa_pkg::cmd_e       cmd1_q;
  iqa_pkg::prod_t      prod_d [NComp][NComp];
  iqa_pkg::prod_t      prod_q [NComp][NComp];
  iqa_pkg::res_t       simple_d [NComp];
  iqa_pkg::res_t       simple_q [NComp];

  logic                out_valid_q;
  iqa_pkg::res_t       res_d [NComp];
  iqa_pkg::res_t       res_q [NComp];

  // The whole pipeline moves unless a result beat waits downstream.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign cmd_in          = iqa_pkg::cmd_e'(s_axis_tuser_i);

  // Unpack operands; in square mode q is fed to both multiplier inputs.
  always_comb begin
    for (int c = 0; c < NComp; c++) begin
      p_op[c] = s_axis_tdata_i[c*CompW +: CompW];
      q_op[c] = s_axis_tdata_i[(c+NComp)*CompW +: CompW];
      a_op[c] = (cmd_in == iqa_pkg::CMD_SQUARE) ? q_op[c] : p_op[c];
    end
  end

  // Stage 1: all cross products.
  always_comb begin
    for (int a = 0; a < NComp; a++) begin
      for (int b = 0; b < NComp; b++) begin
        prod_d[a][b] = iqa_pkg::ProdW'(a_op[a]) * iqa_pkg::ProdW'(q_op[b]);
      end
    end
  end

  // Stage 1: results that need no multiplier.
  always_comb begin
    for (int c = 0; c < NComp; c++) begin
      unique case (cmd_in)
        iqa_pkg::CMD_ADD: simple_d[c] = iqa_pkg::ResW'(p_op[c]) + iqa_pkg::ResW'(q_op[c]);
        iqa_pkg::CMD_SUB: simple_d[c] = iqa_pkg::ResW'(p_op[c]) - iqa_pkg::ResW'(q_op[c]);
        iqa_pkg::CMD_CONJ: begin
          simple_d[c] = (c == 0) ? iqa_pkg::ResW'(q_op[c]) : -iqa_pkg::ResW'(q_op[c]);
        end
        default: simple_d[c] = '0;
      endcase
    end
  end

  // Stage 1 control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else if (advance) begin
      valid1_q <= s_axis_tvalid_i;
    end
  end

  // Stage 1 data.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      cmd1_q   <= cmd_in;
      prod_q   <= prod_d;
      simple_q <= simple_d;
    end
  end

  // Stage 2: signed sums of the products and final selection.
  always_comb begin
    iqa_pkg::res_t acc;
    iqa_pkg::res_t term;
    logic          neg;
    for (int c = 0; c < NComp; c++) begin
      acc = '0;
      for (int t = 0; t < NComp; t++) begin
        term = iqa_pkg::ResW'(prod_q[iqa_pkg::TermPIdx[c][t]][iqa_pkg::TermQIdx[c][t]]);
        // Conjugating q flips every term that uses an imaginary part of q.
        neg  = iqa_pkg::TermNeg[c][t] ^
               ((cmd1_q == iqa_pkg::CMD_MUL_CONJ) && (iqa_pkg::TermQIdx[c][t] != 2'd0));
        acc  = neg ? (acc - term) : (acc + term);
      end
      unique case (cmd1_q)
        iqa_pkg::CMD_MUL,
        iqa_pkg::CMD_MUL_CONJ: res_d[c] = acc;
        iqa_pkg::CMD_SQUARE:   res_d[c] = iqa_pkg::ResW'(prod_q[c][c]);
        default:               res_d[c] = simple_q[c];
      endcase
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= valid1_q;
    end
  end

  // Output register data.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tdata_o = {res_q[3], res_q[2], res_q[1], res_q[0]};

endmodule
